// ===== rtl/core/mprc_pkg.sv =====
// mprc_pkg: shared types, codes and constants of the motion phase repetition counter
// depends on nothing; used by mprc_core and motion_phase_repetition_counter
package mprc_pkg;

    // timestamp and register widths
    localparam int TIME_BITS  = 40;
    localparam int CFG_BITS   = 16;
    localparam int TOTAL_BITS = 32;
    localparam int CFG_IDX_BITS = 2;

    // register reset values
    localparam logic [CFG_BITS-1:0] MIN_CYCLE_RESET  = 16'd600;
    localparam logic [CFG_BITS-1:0] MAX_CYCLE_RESET  = 16'd10000;
    localparam logic [CFG_BITS-1:0] REFRACTORY_RESET = 16'd300;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_CYCLE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_CYCLE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REFRACTORY = 2'd2;

    // request kinds
    localparam logic KIND_SAMPLE      = 1'b0;
    localparam logic KIND_CYCLE_RESET = 1'b1;

    // phase codes; the unused code also marks "no candidate"
    localparam logic [1:0] PH_REST      = 2'd0;
    localparam logic [1:0] PH_PRIMARY   = 2'd1;
    localparam logic [1:0] PH_SECONDARY = 2'd2;
    localparam logic [1:0] PH_NONE      = 2'd3;

    // a phase is stable after this many consecutive sightings
    localparam logic [1:0] STABLE_COUNT = 2'd2;

    // result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TIME_BACK = 1'b1;

    typedef enum logic [1:0] {
        ST_WAIT_PRIMARY   = 2'd0,
        ST_WAIT_SECONDARY = 2'd1,
        ST_WAIT_REST      = 2'd2
    } cyc_state_t;

    typedef struct packed {
        logic                 kind;
        logic [1:0]           phase;
        logic [TIME_BITS-1:0] now_ms;
    } mprc_in_t;

    typedef struct packed {
        logic                  status;
        logic                  rep_done;
        logic [TOTAL_BITS-1:0] rep_total;
    } mprc_out_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] min_len;
        logic [CFG_BITS-1:0] max_len;
        logic [CFG_BITS-1:0] hold_gap;
    } mprc_cfg_t;

endpackage

// ===== rtl/core/mprc_core.sv =====
// mprc_core: cycle state machine, phase debounce and repetition total
// depends on mprc_pkg; one request is applied per cycle when step_en is high
module mprc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  mprc_pkg::mprc_in_t  item,
    input  mprc_pkg::mprc_cfg_t cfg,
    output mprc_pkg::mprc_out_t result
);

    localparam int TB = mprc_pkg::TIME_BITS;
    localparam int PAD = mprc_pkg::TIME_BITS - mprc_pkg::CFG_BITS;

    mprc_pkg::cyc_state_t               state_reg, state_next;
    logic [1:0]                         cand_reg, cand_next;
    logic [1:0]                         stable_reg, stable_next;
    logic [TB-1:0]                      begin_reg, begin_next;
    logic [TB-1:0]                      last_sample_reg, last_sample_next;
    logic [TB-1:0]                      last_count_reg, last_count_next;
    logic [mprc_pkg::TOTAL_BITS-1:0]    total_reg, total_next;
    logic                               status_c;
    logic                               done_c;

    logic [TB-1:0] min_ext, max_ext, refr_ext;
    logic [TB-1:0] age;
    logic [TB-1:0] gap;

    assign min_ext  = {{PAD{1'b0}}, cfg.min_len};
    assign max_ext  = {{PAD{1'b0}}, cfg.max_len};
    assign refr_ext = {{PAD{1'b0}}, cfg.hold_gap};

    // time since the open cycle began and since the last count, modulo 2^TB
    assign age = item.now_ms - begin_reg;
    assign gap = item.now_ms - last_count_reg;

    // next state
    always_comb begin
        mprc_pkg::cyc_state_t cs;
        logic [1:0]           cand;
        logic [1:0]           sc;
        logic [TB-1:0]        cb;
        logic [TB-1:0]        len;
        logic                 len_ok;
        logic                 gap_ok;

        state_next       = state_reg;
        cand_next        = cand_reg;
        stable_next      = stable_reg;
        begin_next       = begin_reg;
        last_sample_next = last_sample_reg;
        last_count_next  = last_count_reg;
        total_next       = total_reg;
        status_c         = mprc_pkg::STATUS_OK;
        done_c           = 1'b0;
        cs     = state_reg;
        cand   = cand_reg;
        sc     = stable_reg;
        cb     = begin_reg;
        len    = '0;
        len_ok = 1'b0;
        gap_ok = 1'b0;

        if (item.kind == mprc_pkg::KIND_CYCLE_RESET) begin
            state_next  = mprc_pkg::ST_WAIT_PRIMARY;
            cand_next   = mprc_pkg::PH_NONE;
            stable_next = '0;
            begin_next  = '0;
        end else if (item.phase != mprc_pkg::PH_NONE) begin
            if (last_sample_reg != '0 && item.now_ms < last_sample_reg) begin
                status_c = mprc_pkg::STATUS_TIME_BACK;
            end else begin
                last_sample_next = item.now_ms;

                // drop a cycle that stayed open too long
                if (cs != mprc_pkg::ST_WAIT_PRIMARY && cb != '0 && age > max_ext) begin
                    cs   = mprc_pkg::ST_WAIT_PRIMARY;
                    cand = mprc_pkg::PH_NONE;
                    sc   = '0;
                    cb   = '0;
                end

                // debounce, then step the cycle on a stable phase
                if (cand != item.phase) begin
                    cand = item.phase;
                    sc   = 2'd1;
                end else begin
                    if (sc < mprc_pkg::STABLE_COUNT) begin
                        sc = sc + 2'd1;
                    end
                    if (sc >= mprc_pkg::STABLE_COUNT) begin
                        case (cs)
                            mprc_pkg::ST_WAIT_PRIMARY: begin
                                if (item.phase == mprc_pkg::PH_PRIMARY) begin
                                    cb = item.now_ms;
                                    cs = mprc_pkg::ST_WAIT_SECONDARY;
                                end
                            end
                            mprc_pkg::ST_WAIT_SECONDARY: begin
                                if (item.phase == mprc_pkg::PH_PRIMARY) begin
                                    cb = item.now_ms;
                                end else if (item.phase == mprc_pkg::PH_SECONDARY) begin
                                    cs = mprc_pkg::ST_WAIT_REST;
                                end
                            end
                            mprc_pkg::ST_WAIT_REST: begin
                                if (item.phase == mprc_pkg::PH_REST) begin
                                    len    = item.now_ms - cb;
                                    len_ok = (len >= min_ext) && (len <= max_ext);
                                    gap_ok = (total_reg == '0) || (gap >= refr_ext);
                                    cs     = mprc_pkg::ST_WAIT_SECONDARY;
                                    cb     = item.now_ms;
                                    if (len_ok && gap_ok) begin
                                        done_c          = 1'b1;
                                        last_count_next = item.now_ms;
                                        if (total_reg != '1) begin
                                            total_next = total_reg + 1'b1;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                state_next  = cs;
                cand_next   = cand;
                stable_next = sc;
                begin_next  = cb;
            end
        end
    end

    // result of the request
    always_comb begin
        result.status    = status_c;
        result.rep_done  = done_c;
        result.rep_total = total_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mprc_pkg::ST_WAIT_PRIMARY;
            cand_reg        <= mprc_pkg::PH_NONE;
            stable_reg      <= '0;
            begin_reg       <= '0;
            last_sample_reg <= '0;
            last_count_reg  <= '0;
            total_reg       <= '0;
        end else if (step_en) begin
            state_reg       <= state_next;
            cand_reg        <= cand_next;
            stable_reg      <= stable_next;
            begin_reg       <= begin_next;
            last_sample_reg <= last_sample_next;
            last_count_reg  <= last_count_next;
            total_reg       <= total_next;
        end
    end

endmodule

// ===== rtl/core/motion_phase_repetition_counter.sv =====
// motion_phase_repetition_counter: top level with request register, result register
// and configuration registers; depends on mprc_pkg and mprc_core
//
// Usage:
//   s_valid/s_ready/s_data carry requests: a timestamped phase sample or a
//   cycle-reset command. m_valid/m_ready/m_data return exactly one result per
//   request: status, rep_done and the running repetition total.
//   cfg_wr_en/cfg_index/cfg_wdata write the shortest cycle (0), the longest
//   cycle (1) and the refractory gap (2); write them only while no request is
//   in flight.
// Path: an accepted request waits in the request register, then passes to the result
//   register and so to m_valid once the result register is free or being emptied.
// Throughput: one request per cycle while the result register is free or being
//   emptied; the state update is a single pass of 40-bit subtracts and compares
//   between the request and result registers.
// Reset (aresetn low, synchronous): both channels empty, cycle state back to
//   waiting for primary, total and timestamps cleared, registers to defaults.
// Receiver stall: the result register holds; the request register still takes
//   one more request, then s_ready drops until the result is taken.
module motion_phase_repetition_counter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mprc_pkg::mprc_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mprc_pkg::mprc_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [mprc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mprc_pkg::CFG_BITS-1:0]       cfg_wdata
);

    logic                 in_valid_reg;
    mprc_pkg::mprc_in_t   in_data_reg;
    logic                 out_valid_reg;
    mprc_pkg::mprc_out_t  out_data_reg;
    mprc_pkg::mprc_cfg_t  cfg_reg;
    mprc_pkg::mprc_out_t  step_result;
    logic                 step_en;

    // a request is processed when the result slot is free or being emptied
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= step_result;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_len  <= mprc_pkg::MIN_CYCLE_RESET;
            cfg_reg.max_len  <= mprc_pkg::MAX_CYCLE_RESET;
            cfg_reg.hold_gap <= mprc_pkg::REFRACTORY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mprc_pkg::CFG_MIN_CYCLE:  cfg_reg.min_len  <= cfg_wdata;
                mprc_pkg::CFG_MAX_CYCLE:  cfg_reg.max_len  <= cfg_wdata;
                mprc_pkg::CFG_REFRACTORY: cfg_reg.hold_gap <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mprc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

endmodule

// ===== tb/motion_phase_repetition_counter_test.sv =====
// motion_phase_repetition_counter_test: self-checking bench for the repetition counter,
// with a request driver, a result monitor and a request-level predictor of the count
// depends on mprc_pkg and motion_phase_repetition_counter
module motion_phase_repetition_counter_test;
    import mprc_pkg::*;

    // sender gaps and paced receiver stalls stay well below this limit,
    // so anything near this many quiet cycles means the block has hung
    localparam int STALL_LIMIT = 2000;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PACED
    } ready_mode_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    mprc_in_t                s_data = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    mprc_out_t               m_data;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_wdata = '0;

    // request stream and expected results
    mprc_in_t  sample_q[$];
    mprc_out_t rep_expect_q[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    logic      req_taken = 1'b0;

    // predictor state
    mprc_cfg_t            limits;
    cyc_state_t           phase_state;
    logic [1:0]           cand_phase;
    logic [1:0]           seen_count;
    logic [TIME_BITS-1:0] open_start;
    logic [TIME_BITS-1:0] last_sample_ms;
    logic [TIME_BITS-1:0] prev_rep_stamp;
    logic [TOTAL_BITS-1:0] rep_count;

    // stimulus time base
    logic [TIME_BITS-1:0] stamp_ms = '0;

    // driver pacing
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    // receiver pacing
    ready_mode_t rdy_mode = RDY_ALWAYS;
    int unsigned mode_left = 0;
    int unsigned pace = 2;
    int unsigned pace_tick = 0;

    motion_phase_repetition_counter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // drop the open cycle, keeping the total and the last sample and count timestamps
    task automatic abandon_cycle();
        phase_state = ST_WAIT_PRIMARY;
        cand_phase = PH_NONE;
        seen_count = '0;
        open_start = '0;
    endtask

    // update the count for one request and return the result it produces
    task automatic count_repetition(input mprc_in_t req, output mprc_out_t res);
        logic [TIME_BITS-1:0] cycle_len;
        logic [TIME_BITS-1:0] rep_gap;
        logic                 len_ok;
        logic                 gap_ok;
        res.status = STATUS_OK;
        res.rep_done = 1'b0;
        if (req.kind == KIND_CYCLE_RESET) begin
            abandon_cycle();
        end else if (req.phase != PH_NONE) begin
            if (last_sample_ms != '0 && req.now_ms < last_sample_ms) begin
                res.status = STATUS_TIME_BACK;
            end else begin
                last_sample_ms = req.now_ms;
                cycle_len = req.now_ms - open_start;
                // stale open cycle
                if (phase_state != ST_WAIT_PRIMARY && open_start != '0 &&
                    cycle_len > limits.max_len)
                    abandon_cycle();
                if (cand_phase != req.phase) begin
                    cand_phase = req.phase;
                    seen_count = 2'd1;
                end else begin
                    if (seen_count < STABLE_COUNT)
                        seen_count = seen_count + 2'd1;
                    // stable phase steps the cycle machine
                    if (seen_count >= STABLE_COUNT) begin
                        case (phase_state)
                            ST_WAIT_PRIMARY: begin
                                if (req.phase == PH_PRIMARY) begin
                                    open_start = req.now_ms;
                                    phase_state = ST_WAIT_SECONDARY;
                                end
                            end
                            ST_WAIT_SECONDARY: begin
                                if (req.phase == PH_PRIMARY)
                                    open_start = req.now_ms;
                                else if (req.phase == PH_SECONDARY)
                                    phase_state = ST_WAIT_REST;
                            end
                            ST_WAIT_REST: begin
                                if (req.phase == PH_REST) begin
                                    cycle_len = req.now_ms - open_start;
                                    rep_gap = req.now_ms - prev_rep_stamp;
                                    len_ok = cycle_len >= limits.min_len &&
                                             cycle_len <= limits.max_len;
                                    gap_ok = rep_count == '0 ||
                                             rep_gap >= limits.hold_gap;
                                    phase_state = ST_WAIT_SECONDARY;
                                    open_start = req.now_ms;
                                    if (len_ok && gap_ok) begin
                                        if (rep_count != '1)
                                            rep_count = rep_count + 1'b1;
                                        prev_rep_stamp = req.now_ms;
                                        res.rep_done = 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
        res.rep_total = rep_count;
    endtask

    function automatic void check_field(input string field,
                                        input logic [TOTAL_BITS-1:0] want,
                                        input logic [TOTAL_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // monitor: check results, predict accepted requests, watch for a hang
    always @(posedge aclk) begin
        mprc_out_t want;
        mprc_out_t pred;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (rep_expect_q.size() == 0) begin
                    $display("%0t: result with no request pending, expected none actual %0d",
                             $time, m_data.rep_total);
                    mismatches++;
                end else begin
                    want = rep_expect_q.pop_front();
                    check_field("status", TOTAL_BITS'(want.status),
                                TOTAL_BITS'(m_data.status));
                    check_field("rep_done", TOTAL_BITS'(want.rep_done),
                                TOTAL_BITS'(m_data.rep_done));
                    check_field("rep_total", want.rep_total, m_data.rep_total);
                end
            end
            if (s_valid && s_ready) begin
                count_repetition(s_data, pred);
                rep_expect_q.push_back(pred);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // driver: bursts of requests with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                s_data <= sample_q.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 15);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: switches between always ready, random and paced stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (mode_left == 0) begin
            rdy_mode <= ready_mode_t'($urandom_range(0, 2));
            mode_left <= $urandom_range(30, 200);
            pace <= $urandom_range(2, 12);
            pace_tick <= 0;
            m_ready <= 1'b1;
        end else begin
            mode_left <= mode_left - 1;
            pace_tick <= (pace_tick + 1 >= pace) ? 0 : pace_tick + 1;
            case (rdy_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                default:    m_ready <= (pace_tick == 0);
            endcase
        end
    end

    // hang detection
    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("%0t: nothing moved for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic push_req(input logic kind, input logic [1:0] phase,
                            input logic [TIME_BITS-1:0] now);
        mprc_in_t req;
        req.kind = kind;
        req.phase = phase;
        req.now_ms = now;
        sample_q.push_back(req);
    endtask

    // wait until every request is in and every result is out
    task automatic drain();
        while (sample_q.size() != 0 || s_valid || rep_expect_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MIN_CYCLE:  limits.min_len = val;
            CFG_MAX_CYCLE:  limits.max_len = val;
            CFG_REFRACTORY: limits.hold_gap = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(input logic [CFG_BITS-1:0] min_ms,
                              input logic [CFG_BITS-1:0] max_ms,
                              input logic [CFG_BITS-1:0] refr_ms);
        drain();
        write_reg(CFG_MIN_CYCLE, min_ms);
        write_reg(CFG_MAX_CYCLE, max_ms);
        write_reg(CFG_REFRACTORY, refr_ms);
    endtask

    // mostly full primary/secondary/rest cycles, plus noise and broken sequences
    task automatic queue_random(input int count);
        logic [1:0]  order [3];
        int          added;
        int unsigned pick;
        int unsigned step_hi;
        int unsigned reps;
        order = '{PH_PRIMARY, PH_SECONDARY, PH_REST};
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 5))
                    0:       step_hi = 0;
                    1:       step_hi = 20;
                    2:       step_hi = 150;
                    3:       step_hi = 400;
                    default: step_hi = 3000;
                endcase
                for (int p = 0; p < 3; p++) begin
                    reps = $urandom_range(2, 3);
                    for (int r = 0; r < reps; r++) begin
                        stamp_ms = stamp_ms + $urandom_range(0, step_hi);
                        push_req(KIND_SAMPLE, order[p], stamp_ms);
                        added++;
                    end
                end
            end else if (pick < 78) begin
                stamp_ms = stamp_ms + $urandom_range(0, 500);
                push_req(KIND_SAMPLE, 2'($urandom_range(0, 3)), stamp_ms);
                added++;
            end else if (pick < 84) begin
                push_req(KIND_CYCLE_RESET, 2'($urandom_range(0, 3)),
                         TIME_BITS'({$urandom, $urandom}));
                added++;
            end else if (pick < 90) begin
                if (stamp_ms > 1) begin
                    push_req(KIND_SAMPLE, 2'($urandom_range(0, 2)),
                             TIME_BITS'(64'({$urandom, $urandom}) % stamp_ms));
                    added++;
                end
            end else if (pick < 95) begin
                // long silence: ages out open cycles and reaches high time bits
                if (stamp_ms < (TIME_MAX >> 2))
                    stamp_ms = TIME_BITS'(stamp_ms +
                               ({$urandom, $urandom} >> $urandom_range(26, 63)));
            end else begin
                // flicker between primary and secondary without settling
                for (int f = 0; f < 4; f++) begin
                    stamp_ms = stamp_ms + $urandom_range(0, 200);
                    push_req(KIND_SAMPLE, (f % 2 == 0) ? PH_PRIMARY : PH_SECONDARY, stamp_ms);
                    added++;
                end
            end
        end
    endtask

    // stimulus
    initial begin
        limits.min_len = MIN_CYCLE_RESET;
        limits.max_len = MAX_CYCLE_RESET;
        limits.hold_gap = REFRACTORY_RESET;
        abandon_cycle();
        last_sample_ms = '0;
        prev_rep_stamp = '0;
        rep_count = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // widest window and longest refractory gap
        set_limits(16'd0, 16'hFFFF, 16'hFFFF);
        // unused phase code is ignored
        push_req(KIND_SAMPLE, PH_NONE, 40'd5);
        // zero timestamps leave the cycle start empty, so the timeout is skipped
        push_req(KIND_SAMPLE, PH_REST, 40'd0);
        push_req(KIND_SAMPLE, PH_PRIMARY, 40'd0);
        push_req(KIND_SAMPLE, PH_PRIMARY, 40'd0);
        push_req(KIND_SAMPLE, PH_SECONDARY, 40'd50000);
        push_req(KIND_SAMPLE, PH_SECONDARY, 40'd50000);
        push_req(KIND_SAMPLE, PH_REST, 40'd50010);
        // first count ignores the refractory gap
        push_req(KIND_SAMPLE, PH_REST, 40'd50010);
        // a further repetition falls inside the refractory gap and is not counted
        push_req(KIND_SAMPLE, PH_PRIMARY, 40'd50100);
        push_req(KIND_SAMPLE, PH_PRIMARY, 40'd50110);
        push_req(KIND_SAMPLE, PH_SECONDARY, 40'd50300);
        push_req(KIND_SAMPLE, PH_SECONDARY, 40'd50310);
        push_req(KIND_SAMPLE, PH_REST, 40'd50500);
        push_req(KIND_SAMPLE, PH_REST, 40'd50510);
        // timestamp going backwards
        push_req(KIND_SAMPLE, PH_PRIMARY, 40'd100);
        // cycle reset command with junk fields
        push_req(KIND_CYCLE_RESET, PH_NONE, TIME_MAX);
        // open cycle outlives the maximum and is dropped
        push_req(KIND_SAMPLE, PH_PRIMARY, 40'd60000);
        push_req(KIND_SAMPLE, PH_PRIMARY, 40'd60010);
        push_req(KIND_SAMPLE, PH_SECONDARY, 40'd200000);
        push_req(KIND_SAMPLE, PH_SECONDARY, 40'd200010);
        stamp_ms = 40'd200010;

        set_limits(MIN_CYCLE_RESET, MAX_CYCLE_RESET, REFRACTORY_RESET);
        queue_random(145);
        set_limits(CFG_BITS'($urandom_range(0, 3000)), CFG_BITS'($urandom_range(0, 16000)),
                   CFG_BITS'($urandom_range(0, 5000)));
        queue_random(145);
        set_limits(16'hFFFF, 16'hFFFF, 16'd0);
        queue_random(145);
        set_limits(CFG_BITS'($urandom_range(0, 3000)), CFG_BITS'($urandom_range(0, 16000)),
                   CFG_BITS'($urandom_range(0, 5000)));
        queue_random(145);
        set_limits(16'd0, 16'd1500, 16'd0);
        queue_random(145);

        // cycle near TIME_MAX outlives the maximum; the wrap to zero goes back in time
        push_req(KIND_SAMPLE, PH_PRIMARY, TIME_MAX - 40'd5000);
        push_req(KIND_SAMPLE, PH_PRIMARY, TIME_MAX - 40'd4990);
        push_req(KIND_SAMPLE, PH_SECONDARY, TIME_MAX - 40'd3000);
        push_req(KIND_SAMPLE, PH_SECONDARY, TIME_MAX - 40'd2990);
        push_req(KIND_SAMPLE, PH_REST, TIME_MAX - 40'd1);
        push_req(KIND_SAMPLE, PH_REST, TIME_MAX);
        push_req(KIND_SAMPLE, PH_REST, 40'd0);
        push_req(KIND_SAMPLE, PH_NONE, TIME_MAX);

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
